### rtl/core/ppp_pkg.sv
// Shared constants and types for the pinhole point projection block.
`timescale 1ns / 1ps
package ppp_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CFG_IDX_W      = 3;

    // Integer parts of the reset camera model.
    localparam int FOCAL_RESET_INT    = 500;
    localparam int CENTER_X_RESET_INT = 320;
    localparam int CENTER_Y_RESET_INT = 240;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_MIN_DEPTH = 3'd4
    } reg_index_t;

    // Per-item flags that travel beside the dividers.
    typedef struct packed {
        logic pass;
        logic xneg;
        logic xpos;
        logic yneg;
        logic ypos;
    } ppp_flags_t;

endpackage

### rtl/core/ppp_if.sv
// Stream interfaces for points in and projection results out.
`timescale 1ns / 1ps
interface ppp_pt_if #(parameter int W = ppp_pkg::DATA_WIDTH_DEF) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;
    logic signed [W-1:0] observed_u;
    logic signed [W-1:0] observed_v;

    modport source (output valid, point_x, point_y, point_z, observed_u, observed_v,
                    input ready);
    modport sink (input valid, point_x, point_y, point_z, observed_u, observed_v,
                  output ready);
endinterface

interface ppp_res_if #(parameter int W = ppp_pkg::DATA_WIDTH_DEF) ();
    logic                valid;
    logic                ready;
    logic                valid_res;
    logic signed [W-1:0] proj_u;
    logic signed [W-1:0] proj_v;
    logic signed [W-1:0] resid_u;
    logic signed [W-1:0] resid_v;
    logic signed [W-1:0] jac_u_x;
    logic signed [W-1:0] jac_u_z;
    logic signed [W-1:0] jac_v_y;
    logic signed [W-1:0] jac_v_z;

    modport source (output valid, valid_res, proj_u, proj_v, resid_u, resid_v,
                    jac_u_x, jac_u_z, jac_v_y, jac_v_z, input ready);
    modport sink (input valid, valid_res, proj_u, proj_v, resid_u, resid_v,
                  jac_u_x, jac_u_z, jac_v_y, jac_v_z, output ready);
endinterface

### rtl/core/pinhole_point_projection.sv
// Throughput: one point per cycle while the output is not stalled; six dividers
// retire one quotient bit per stage. A stalled output holds every stage; no
// transaction is lost or repeated. Reset clears all valid bits and loads focal
// 500, center (320, 240), min depth 0. Configuration writes must come only
// between points; the block does not enforce this. The pipeline reads them live.
`timescale 1ns / 1ps
module pinhole_point_projection #(
    parameter int DATA_WIDTH = ppp_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = ppp_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ppp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_WIDTH-1:0]         cfg_data,
    ppp_pt_if.sink                        points,
    ppp_res_if.source                     results
);
    import ppp_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + 1;

    localparam logic [W-2:0] FOCAL_RST = (W-1)'(FOCAL_RESET_INT) << F;
    localparam logic [W-1:0] CX_RST    = W'(CENTER_X_RESET_INT) << F;
    localparam logic [W-1:0] CY_RST    = W'(CENTER_Y_RESET_INT) << F;

    logic [W-2:0]        fx_reg, fy_reg, mind_reg;
    logic signed [W-1:0] cx_reg, cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg   <= FOCAL_RST;
            fy_reg   <= FOCAL_RST;
            cx_reg   <= CX_RST;
            cy_reg   <= CY_RST;
            mind_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_FOCAL_X:   fx_reg   <= cfg_data[W-2:0];
                REG_FOCAL_Y:   fy_reg   <= cfg_data[W-2:0];
                REG_CENTER_X:  cx_reg   <= cfg_data;
                REG_CENTER_Y:  cy_reg   <= cfg_data;
                REG_MIN_DEPTH: mind_reg <= cfg_data[W-2:0];
                default:       ;
            endcase
        end
    end

    // Whole pipeline advances together; the output register holds on stall.
    logic en;
    assign en           = !results.valid || results.ready;
    assign points.ready = en;

    // Stage 1: capture the transaction.
    logic                v1_reg;
    logic signed [W-1:0] x1_reg, y1_reg, z1_reg, ou1_reg, ov1_reg;

    // Stage 2: depth test and full products.
    logic                v2_reg;
    ppp_flags_t          f2_reg;
    logic [2*W-2:0]      nx_reg, ny_reg;
    logic [2*W-3:0]      zz_reg;
    logic [W-2:0]        z2_reg;
    logic signed [W-1:0] ou2_reg, ov2_reg;

    logic [W-1:0]        ax, ay;
    logic [W-2:0]        zl;
    ppp_flags_t          f1;

    assign ax = x1_reg[W-1] ? (~x1_reg + 1'b1) : x1_reg;
    assign ay = y1_reg[W-1] ? (~y1_reg + 1'b1) : y1_reg;
    assign zl = z1_reg[W-2:0];

    always_comb
    begin
        f1.pass = z1_reg > $signed({1'b0, mind_reg});
        f1.xneg = x1_reg[W-1];
        f1.xpos = !x1_reg[W-1] && (|x1_reg);
        f1.yneg = y1_reg[W-1];
        f1.ypos = !y1_reg[W-1] && (|y1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= points.valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= points.point_x;
            y1_reg  <= points.point_y;
            z1_reg  <= points.point_z;
            ou1_reg <= points.observed_u;
            ov1_reg <= points.observed_v;

            f2_reg  <= f1;
            nx_reg  <= {{W{1'b0}}, fx_reg} * {{(W-1){1'b0}}, ax};
            ny_reg  <= {{W{1'b0}}, fy_reg} * {{(W-1){1'b0}}, ay};
            zz_reg  <= {{(W-1){1'b0}}, zl} * {{(W-1){1'b0}}, zl};
            z2_reg  <= zl;
            ou2_reg <= ou1_reg;
            ov2_reg <= ov1_reg;
        end
    end

    // Dividers: projection, focal over depth, and depth-squared terms.
    logic [QW:0] m_u, m_v, m_jux, m_jvy, m_juz, m_jvz;

    ppp_div #(.NUM_W(2*W-1), .DEN_W(W-1), .QW(QW)) u_div_u (
        .clk(clk), .en(en), .num(nx_reg), .den(z2_reg), .mag(m_u));
    ppp_div #(.NUM_W(2*W-1), .DEN_W(W-1), .QW(QW)) u_div_v (
        .clk(clk), .en(en), .num(ny_reg), .den(z2_reg), .mag(m_v));
    ppp_div #(.NUM_W(W-1+F), .DEN_W(W-1), .QW(QW)) u_div_jux (
        .clk(clk), .en(en), .num({fx_reg, {F{1'b0}}}), .den(z2_reg), .mag(m_jux));
    ppp_div #(.NUM_W(W-1+F), .DEN_W(W-1), .QW(QW)) u_div_jvy (
        .clk(clk), .en(en), .num({fy_reg, {F{1'b0}}}), .den(z2_reg), .mag(m_jvy));
    ppp_div #(.NUM_W(2*W-1+F), .DEN_W(2*W-2), .QW(QW)) u_div_juz (
        .clk(clk), .en(en), .num({nx_reg, {F{1'b0}}}), .den(zz_reg), .mag(m_juz));
    ppp_div #(.NUM_W(2*W-1+F), .DEN_W(2*W-2), .QW(QW)) u_div_jvz (
        .clk(clk), .en(en), .num({ny_reg, {F{1'b0}}}), .den(zz_reg), .mag(m_jvz));

    // Side pipe matching the divider latency.
    logic                vs_reg  [0:QW];
    ppp_flags_t          fs_reg  [0:QW];
    logic signed [W-1:0] ous_reg [0:QW];
    logic signed [W-1:0] ovs_reg [0:QW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                vs_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vs_reg[0] <= v2_reg;
            for (int k = 1; k <= QW; k++)
            begin
                vs_reg[k] <= vs_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fs_reg[0]  <= f2_reg;
            ous_reg[0] <= ou2_reg;
            ovs_reg[0] <= ov2_reg;
            for (int k = 1; k <= QW; k++)
            begin
                fs_reg[k]  <= fs_reg[k-1];
                ous_reg[k] <= ous_reg[k-1];
                ovs_reg[k] <= ovs_reg[k-1];
            end
        end
    end

    ppp_out #(.W(W)) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .v_in  (vs_reg[QW]),
        .flags (fs_reg[QW]),
        .ou    (ous_reg[QW]),
        .ov    (ovs_reg[QW]),
        .cx    (cx_reg),
        .cy    (cy_reg),
        .m_u   (m_u),
        .m_v   (m_v),
        .m_jux (m_jux),
        .m_jvy (m_jvy),
        .m_juz (m_juz),
        .m_jvz (m_jvz),
        .res   (results)
    );

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |-> !points.ready)
        else $error("input accepted while output stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.valid_res) |->
            (results.proj_u == '0 && results.resid_v == '0 && results.jac_v_z == '0))
        else $error("rejected point carries nonzero fields");

    a_jac_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (!results.jac_u_x[W-1] && !results.jac_v_y[W-1]))
        else $error("focal over depth went negative");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.ready) |=> $stable(vs_reg[QW]) && $stable(v2_reg))
        else $error("pipeline moved during stall");

endmodule

### rtl/core/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, clamped quotient.
`timescale 1ns / 1ps
module ppp_div #(
    parameter int NUM_W = 63,
    parameter int DEN_W = 31,
    parameter int QW    = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW:0]      mag
);
    localparam int RW = DEN_W + QW;
    localparam int CW = (NUM_W > RW) ? NUM_W : RW;

    logic [RW-1:0]    rem_reg [0:QW];
    logic [DEN_W-1:0] den_reg [0:QW];
    logic [QW-1:0]    q_reg   [0:QW];
    logic             ovf_reg [0:QW];

    logic [CW-1:0] num_ext;
    logic [CW-1:0] lim;
    logic          ovf;

    assign num_ext = CW'(num);
    assign lim     = CW'(den) << QW;
    assign ovf     = num_ext >= lim;

    // Quotients at or above 2^QW all map to the clamp value.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= ovf ? '0 : num_ext[RW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf;
        end
    end

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        localparam int BIT = QW - 1 - j;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(den_reg[j]) << BIT;
        assign ge  = rem_reg[j] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= ge ? (rem_reg[j] - dsh) : rem_reg[j];
                den_reg[j+1] <= den_reg[j];
                q_reg[j+1]   <= q_reg[j] | (ge ? (QW'(1) << BIT) : '0);
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign mag = ovf_reg[QW] ? {1'b1, {QW{1'b0}}} : {1'b0, q_reg[QW]};

endmodule

### rtl/core/ppp_out.sv
// Offset, residual and saturation stages with the output register.
`timescale 1ns / 1ps
module ppp_out #(
    parameter int W = ppp_pkg::DATA_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  v_in,
    input  ppp_pkg::ppp_flags_t   flags,
    input  logic signed [W-1:0]   ou,
    input  logic signed [W-1:0]   ov,
    input  logic signed [W-1:0]   cx,
    input  logic signed [W-1:0]   cy,
    input  logic [W+1:0]          m_u,
    input  logic [W+1:0]          m_v,
    input  logic [W+1:0]          m_jux,
    input  logic [W+1:0]          m_jvy,
    input  logic [W+1:0]          m_juz,
    input  logic [W+1:0]          m_jvz,
    ppp_res_if.source             res
);
    import ppp_pkg::*;

    localparam logic signed [W+3:0] SMAX = {5'b00000, {(W-1){1'b1}}};
    localparam logic signed [W+3:0] SMIN = {5'b11111, {(W-1){1'b0}}};

    function automatic logic signed [W+2:0] apply_sign(input logic [W+1:0] m,
                                                       input logic neg);
        logic signed [W+2:0] s;
        s = $signed({1'b0, m});
        return neg ? -s : s;
    endfunction

    function automatic logic [W-1:0] sat(input logic signed [W+3:0] v);
        logic [W-1:0] r;
        if (v > SMAX)
            r = SMAX[W-1:0];
        else if (v < SMIN)
            r = SMIN[W-1:0];
        else
            r = v[W-1:0];
        return r;
    endfunction

    logic                vE_reg;
    logic                passE_reg;
    logic signed [W+2:0] pu_reg, pv_reg, juz_reg, jvz_reg;
    logic [W+1:0]        jux_reg, jvy_reg;
    logic signed [W-1:0] ouE_reg, ovE_reg;

    logic                valid_reg, vres_reg;
    logic [W-1:0]        pu_o_reg, pv_o_reg, ru_o_reg, rv_o_reg;
    logic [W-1:0]        jux_o_reg, juz_o_reg, jvy_o_reg, jvz_o_reg;

    logic signed [W+3:0] ru_w, rv_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vE_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vE_reg    <= v_in;
            valid_reg <= vE_reg;
        end
    end

    // Apply signs to the quotients and add the principal point to the projections.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            passE_reg <= flags.pass;
            pu_reg    <= apply_sign(m_u, flags.xneg) + (W+3)'(cx);
            pv_reg    <= apply_sign(m_v, flags.yneg) + (W+3)'(cy);
            juz_reg   <= apply_sign(m_juz, flags.xpos);
            jvz_reg   <= apply_sign(m_jvz, flags.ypos);
            jux_reg   <= m_jux;
            jvy_reg   <= m_jvy;
            ouE_reg   <= ou;
            ovE_reg   <= ov;
        end
    end

    assign ru_w = (W+4)'(ouE_reg) - (W+4)'(pu_reg);
    assign rv_w = (W+4)'(ovE_reg) - (W+4)'(pv_reg);

    // Saturate each field, and zero every field of a point that fails the depth test.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vres_reg  <= passE_reg;
            pu_o_reg  <= passE_reg ? sat((W+4)'(pu_reg)) : '0;
            pv_o_reg  <= passE_reg ? sat((W+4)'(pv_reg)) : '0;
            ru_o_reg  <= passE_reg ? sat(ru_w) : '0;
            rv_o_reg  <= passE_reg ? sat(rv_w) : '0;
            jux_o_reg <= passE_reg ? sat($signed({2'b00, jux_reg})) : '0;
            jvy_o_reg <= passE_reg ? sat($signed({2'b00, jvy_reg})) : '0;
            juz_o_reg <= passE_reg ? sat((W+4)'(juz_reg)) : '0;
            jvz_o_reg <= passE_reg ? sat((W+4)'(jvz_reg)) : '0;
        end
    end

    assign res.valid     = valid_reg;
    assign res.valid_res = vres_reg;
    assign res.proj_u    = pu_o_reg;
    assign res.proj_v    = pv_o_reg;
    assign res.resid_u   = ru_o_reg;
    assign res.resid_v   = rv_o_reg;
    assign res.jac_u_x   = jux_o_reg;
    assign res.jac_u_z   = juz_o_reg;
    assign res.jac_v_y   = jvy_o_reg;
    assign res.jac_v_z   = jvz_o_reg;

endmodule

### verif/pinhole_point_projection_tb.sv
// Self-checking testbench for the pinhole point projection block.
`timescale 1ns / 1ps
module pinhole_point_projection_tb;
    import ppp_pkg::*;

    localparam int W = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = W + 6;
    localparam logic [127:0] QUOT_LIMIT = 128'd1 << (W + 1);

    typedef struct {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic signed [W-1:0] obs_u;
        logic signed [W-1:0] obs_v;
    } point_t;

    typedef struct {
        logic                valid_res;
        logic signed [W-1:0] proj_u;
        logic signed [W-1:0] proj_v;
        logic signed [W-1:0] resid_u;
        logic signed [W-1:0] resid_v;
        logic signed [W-1:0] jac_u_x;
        logic signed [W-1:0] jac_u_z;
        logic signed [W-1:0] jac_v_y;
        logic signed [W-1:0] jac_v_z;
    } projection_t;

    class projection_scoreboard;
        logic [W-2:0]        focal_x;
        logic [W-2:0]        focal_y;
        logic signed [W-1:0] center_x;
        logic signed [W-1:0] center_y;
        logic [W-2:0]        min_depth;
        projection_t         pending[$];
        int                  errors;

        function new();
            focal_x = (W-1)'(FOCAL_RESET_INT) << FB;
            focal_y = (W-1)'(FOCAL_RESET_INT) << FB;
            center_x = W'(CENTER_X_RESET_INT) << FB;
            center_y = W'(CENTER_Y_RESET_INT) << FB;
            min_depth = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [W-1:0] data);
            case (idx)
                REG_FOCAL_X:   focal_x = data[W-2:0];
                REG_FOCAL_Y:   focal_y = data[W-2:0];
                REG_CENTER_X:  center_x = data;
                REG_CENTER_Y:  center_y = data;
                REG_MIN_DEPTH: min_depth = data[W-2:0];
                default: ;
            endcase
        endfunction

        // Truncated quotient, magnitude clamped before the sign is applied.
        function logic signed [63:0] qdiv(logic [127:0] num, logic [127:0] den, bit neg);
            logic [127:0] q;
            logic signed [63:0] mag;
            q = num / den;
            mag = (q > QUOT_LIMIT) ? QUOT_LIMIT[63:0] : q[63:0];
            return neg ? -mag : mag;
        endfunction

        function logic signed [W-1:0] sat(logic signed [63:0] v);
            logic signed [63:0] hi;
            logic signed [63:0] lo;
            hi = (64'sd1 <<< (W - 1)) - 1;
            lo = -(64'sd1 <<< (W - 1));
            if (v > hi) return hi[W-1:0];
            if (v < lo) return lo[W-1:0];
            return v[W-1:0];
        endfunction

        function void note_point(point_t p);
            projection_t e;
            logic signed [63:0] xs, ys, zs, pu, pv, ou, ov;
            logic [127:0] ax, ay, den, zz, nx, ny;
            xs = p.x;
            ys = p.y;
            zs = p.z;
            ou = p.obs_u;
            ov = p.obs_v;
            e = '{default: '0};
            if (zs > $signed({33'd0, min_depth}))
            begin
                ax = xs < 0 ? 128'(-xs) : 128'(xs);
                ay = ys < 0 ? 128'(-ys) : 128'(ys);
                den = 128'(zs);
                zz = den * den;
                nx = 128'(focal_x) * ax;
                ny = 128'(focal_y) * ay;
                pu = qdiv(nx, den, xs < 0) + 64'(center_x);
                pv = qdiv(ny, den, ys < 0) + 64'(center_y);
                e.valid_res = 1'b1;
                e.proj_u = sat(pu);
                e.proj_v = sat(pv);
                e.resid_u = sat(ou - pu);
                e.resid_v = sat(ov - pv);
                e.jac_u_x = sat(qdiv(128'(focal_x) << FB, den, 1'b0));
                e.jac_u_z = sat(qdiv(nx << FB, zz, xs > 0));
                e.jac_v_y = sat(qdiv(128'(focal_y) << FB, den, 1'b0));
                e.jac_v_z = sat(qdiv(ny << FB, zz, ys > 0));
            end
            pending.push_back(e);
        endfunction

        function void check_result(projection_t a);
            projection_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, valid_res=%0d proj_u=%0d",
                         $time, a.valid_res, a.proj_u);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.valid_res !== e.valid_res)
            begin
                $display("%0t: valid_res expected %0d actual %0d", $time, e.valid_res,
                         a.valid_res);
                errors++;
            end
            if (a.proj_u !== e.proj_u)
            begin
                $display("%0t: proj_u expected %0d actual %0d", $time, e.proj_u, a.proj_u);
                errors++;
            end
            if (a.proj_v !== e.proj_v)
            begin
                $display("%0t: proj_v expected %0d actual %0d", $time, e.proj_v, a.proj_v);
                errors++;
            end
            if (a.resid_u !== e.resid_u)
            begin
                $display("%0t: resid_u expected %0d actual %0d", $time, e.resid_u, a.resid_u);
                errors++;
            end
            if (a.resid_v !== e.resid_v)
            begin
                $display("%0t: resid_v expected %0d actual %0d", $time, e.resid_v, a.resid_v);
                errors++;
            end
            if (a.jac_u_x !== e.jac_u_x)
            begin
                $display("%0t: jac_u_x expected %0d actual %0d", $time, e.jac_u_x, a.jac_u_x);
                errors++;
            end
            if (a.jac_u_z !== e.jac_u_z)
            begin
                $display("%0t: jac_u_z expected %0d actual %0d", $time, e.jac_u_z, a.jac_u_z);
                errors++;
            end
            if (a.jac_v_y !== e.jac_v_y)
            begin
                $display("%0t: jac_v_y expected %0d actual %0d", $time, e.jac_v_y, a.jac_v_y);
                errors++;
            end
            if (a.jac_v_z !== e.jac_v_z)
            begin
                $display("%0t: jac_v_z expected %0d actual %0d", $time, e.jac_v_z, a.jac_v_z);
                errors++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           cfg_write;
    logic [2:0]     cfg_index;
    logic [W-1:0]   cfg_data;
    bit             no_idle;
    int             hold_request;
    projection_scoreboard sb;

    ppp_pt_if #(.W(W)) pts ();
    ppp_res_if #(.W(W)) res ();

    pinhole_point_projection u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .points    (pts.sink),
        .results   (res.source)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, plus long hold-offs on request.
    initial
    begin
        int held;
        held = 0;
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0 && held == 0)
            begin
                held = hold_request;
                hold_request = 0;
            end
            if (held > 0)
            begin
                res.ready = 1'b0;
                held--;
            end
            else
                res.ready = no_idle ? 1'b1 : ($urandom_range(0, 99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pts.valid && pts.ready)
            sb.note_point('{pts.point_x, pts.point_y, pts.point_z,
                            pts.observed_u, pts.observed_v});
        if (rst_n && res.valid && res.ready)
            sb.check_result('{res.valid_res, res.proj_u, res.proj_v, res.resid_u,
                              res.resid_v, res.jac_u_x, res.jac_u_z, res.jac_v_y,
                              res.jac_v_z});
    end

    task automatic send_point(point_t p);
        if (!no_idle && $urandom_range(0, 99) < 29)
        begin
            @(negedge clk);
            pts.valid = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        pts.valid = 1'b1;
        pts.point_x = p.x;
        pts.point_y = p.y;
        pts.point_z = p.z;
        pts.observed_u = p.obs_u;
        pts.observed_v = p.obs_v;
        do
            @(posedge clk);
        while (!pts.ready);
    endtask

    task automatic write_reg(reg_index_t idx, logic [W-1:0] data);
        @(negedge clk);
        pts.valid = 1'b0;
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Drain everything in flight before touching the registers.
    task automatic drain();
        @(negedge clk);
        pts.valid = 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            2: return $urandom_range(0, 1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
            default: return W'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
        endcase
    endfunction

    function automatic logic [W-1:0] rand_depth();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return $urandom_range(0, 3);
            2: return -$urandom_range(0, 1 << 20);
            3: return $urandom_range(1 << 24, {1'b0, {(W-1){1'b1}}});
            default: return $urandom_range(1 << 12, 1 << 22);
        endcase
    endfunction

    task automatic random_points(int count);
        point_t p;
        repeat (count)
        begin
            p.x = rand_coord();
            p.y = rand_coord();
            p.z = rand_depth();
            p.obs_u = rand_coord();
            p.obs_v = rand_coord();
            send_point(p);
        end
    endtask

    initial
    begin
        logic signed [W-1:0] smax, smin;
        smax = {1'b0, {(W-1){1'b1}}};
        smin = {1'b1, {(W-1){1'b0}}};
        sb = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_idle = 1'b0;
        hold_request = 0;
        pts.valid = 1'b0;
        pts.point_x = '0;
        pts.point_y = '0;
        pts.point_z = '0;
        pts.observed_u = '0;
        pts.observed_v = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset camera, depth edges, coordinate extremes.
        send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 0});
        send_point('{0, 0, 0, 0, 0});
        send_point('{5, 5, -1, 7, 7});
        send_point('{1, -1, smin, 1, 1});
        send_point('{smax, smax, 1, smax, smax});
        send_point('{smin, smin, 1, smin, smin});
        send_point('{smax, smin, smax, smin, smax});
        send_point('{smin, smax, smax, 0, 0});
        send_point('{0, 0, smax, smax, smin});
        send_point('{-3, 3, 2, smin, smax});
        send_point('{32'sh0010_0000, -32'sh0008_0000, 32'sh0004_0000, 0, 0});
        drain();

        // Depth threshold: equal is refused, one above passes.
        write_reg(REG_MIN_DEPTH, 32'h0002_0000);
        write_reg(REG_FOCAL_X, 32'd1);
        write_reg(REG_FOCAL_Y, {1'b0, {(W-1){1'b1}}});
        write_reg(REG_CENTER_X, smin);
        write_reg(REG_CENTER_Y, smax);
        send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 0, 0});
        send_point('{32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0001, 0, 0});
        send_point('{smin, smax, 32'sh0002_0001, smax, smin});
        send_point('{smax, smin, smax, smin, smax});
        send_point('{-1, 1, smax, 0, 0});
        drain();

        write_reg(REG_MIN_DEPTH, {1'b0, {(W-1){1'b1}}});
        send_point('{1, 1, smax, 0, 0});
        send_point('{1, 1, 1, 0, 0});
        drain();

        // Random phases over several camera settings.
        write_reg(REG_MIN_DEPTH, 0);
        write_reg(REG_FOCAL_X, 32'd32768000);
        write_reg(REG_FOCAL_Y, 32'd32768000);
        write_reg(REG_CENTER_X, 32'd20971520);
        write_reg(REG_CENTER_Y, 32'd15728640);
        random_points(300);
        hold_request = 200;
        random_points(300);
        no_idle = 1'b1;
        random_points(250);
        no_idle = 1'b0;
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            write_reg(REG_FOCAL_X, phase == 0 ? 32'd1 : W'($urandom_range(1, 32'h7fff_ffff)));
            write_reg(REG_FOCAL_Y, phase == 1 ? {1'b0, {(W-1){1'b1}}} :
                      W'($urandom_range(1 << 16, 1 << 28)));
            write_reg(REG_CENTER_X, phase == 2 ? smax : $urandom());
            write_reg(REG_CENTER_Y, phase == 3 ? smin : $urandom());
            write_reg(REG_MIN_DEPTH, W'($urandom_range(0, 1 << 14)));
            random_points(290);
            drain();
        end

        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
rtl/core/ppp_pkg.sv
rtl/core/ppp_if.sv
rtl/core/ppp_div.sv
rtl/core/ppp_out.sv
rtl/core/pinhole_point_projection.sv
verif/pinhole_point_projection_tb.sv
